// ===== design/fde_pkg.sv =====
// shared types and constants for the fraction decimal expander
// used by fde_ctrl, fde_dp and fraction_decimal_expander
package fde_pkg;

  localparam int unsigned DataW        = 20;
  localparam int unsigned CountW       = 7;
  localparam int unsigned MAX_DIGITS   = 63;
  localparam int unsigned OperandLimit = 1000000;
  localparam int unsigned DigitW       = 4;
  localparam int unsigned WideW        = DataW + DigitW;
  localparam int unsigned StepW        = 5;

  // one restoring step per quotient bit
  localparam logic [StepW-1:0] IntLastStep = StepW'(DataW - 1);
  localparam logic [StepW-1:0] DigLastStep = StepW'(DigitW - 1);

  typedef enum logic {
    KIND_QUOT  = 1'b0,
    KIND_DIGIT = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INT_DIV,
    ST_EMIT_INT,
    ST_DIG_DIV,
    ST_EMIT_DIG
  } state_t;

  typedef struct packed {
    logic  load_int;
    logic  load_dig;
    logic  step;
    logic  emit;
    kind_t kind;
    logic  last;
  } dp_cmd_t;

  typedef struct packed {
    logic in_ok;
  } dp_stat_t;

endpackage

// ===== design/fde_ctrl.sv =====
// controller state machine: sequences the integer division and digit steps
// depends on fde_pkg
module fde_ctrl import fde_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [CountW-1:0] in_digit_count,
  input  dp_stat_t          stat,
  output dp_cmd_t           cmd,
  output logic              busy
);

  state_t              state_r, state_nxt;
  logic [StepW-1:0]    step_r, step_nxt;
  logic [CountW-1:0]   left_r, left_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      left_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      left_r  <= left_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    left_nxt  = left_r;
    case (state_r)
      ST_IDLE: begin
        if (start && stat.in_ok) begin
          state_nxt = ST_INT_DIV;
          step_nxt  = IntLastStep;
          left_nxt  = in_digit_count;
        end
      end
      ST_INT_DIV: begin
        if (step_r == '0) begin
          state_nxt = ST_EMIT_INT;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      ST_EMIT_INT: begin
        state_nxt = ST_DIG_DIV;
        step_nxt  = DigLastStep;
      end
      ST_DIG_DIV: begin
        if (step_r == '0) begin
          state_nxt = ST_EMIT_DIG;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      ST_EMIT_DIG: begin
        if (left_r == CountW'(1)) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_DIG_DIV;
          step_nxt  = DigLastStep;
          left_nxt  = left_r - 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '{load_int: 1'b0, load_dig: 1'b0, step: 1'b0, emit: 1'b0,
             kind: KIND_QUOT, last: 1'b0};
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy         = 1'b0;
        cmd.load_int = start && stat.in_ok;
      end
      ST_INT_DIV: begin
        cmd.step = 1'b1;
      end
      ST_EMIT_INT: begin
        cmd.emit     = 1'b1;
        cmd.kind     = KIND_QUOT;
        cmd.load_dig = 1'b1;
      end
      ST_DIG_DIV: begin
        cmd.step = 1'b1;
      end
      ST_EMIT_DIG: begin
        cmd.emit     = 1'b1;
        cmd.kind     = KIND_DIGIT;
        cmd.last     = (left_r == CountW'(1));
        cmd.load_dig = (left_r != CountW'(1));
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ===== design/fde_dp.sv =====
// datapath: operand check, restoring divider shared by quotient and digits,
// result register; depends on fde_pkg
module fde_dp import fde_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [DataW-1:0]  in_dividend,
  input  logic [DataW-1:0]  in_divisor,
  input  logic [CountW-1:0] in_digit_count,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  output logic              out_valid,
  output logic              out_kind,
  output logic [DataW-1:0]  out_value,
  output logic              out_last
);

  logic [DataW-1:0] acc_r, acc_nxt;
  logic [DataW-1:0] q_r, q_nxt;
  logic [DataW-1:0] den_r, den_nxt;
  logic             valid_r;
  logic             kind_r;
  logic [DataW-1:0] value_r;
  logic             last_r;

  logic [DataW:0]   trial;
  logic             fits;
  logic [WideW-1:0] wide;

  always_comb begin
    stat.in_ok = (in_dividend != '0) && (in_divisor != '0) && (in_digit_count != '0)
              && (in_dividend <= DataW'(OperandLimit))
              && (in_divisor <= DataW'(OperandLimit))
              && (in_digit_count <= CountW'(MAX_DIGITS));
  end

  // remainder times ten
  assign wide  = ({{DigitW{1'b0}}, acc_r} << 3) + ({{DigitW{1'b0}}, acc_r} << 1);
  assign trial = {acc_r, q_r[DataW-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_comb begin
    acc_nxt = acc_r;
    q_nxt   = q_r;
    den_nxt = den_r;
    if (cmd.load_int) begin
      acc_nxt = '0;
      q_nxt   = in_dividend;
      den_nxt = in_divisor;
    end else if (cmd.load_dig) begin
      // top bits of ten times remainder stay below the divisor
      acc_nxt = wide[WideW-1:DigitW];
      q_nxt   = {wide[DigitW-1:0], {(DataW-DigitW){1'b0}}};
    end else if (cmd.step) begin
      acc_nxt = fits ? DataW'(trial - {1'b0, den_r}) : trial[DataW-1:0];
      q_nxt   = {q_r[DataW-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
    if (cmd.emit) begin
      kind_r  <= cmd.kind;
      last_r  <= cmd.last;
      value_r <= (cmd.kind == KIND_QUOT) ? q_r
                                         : {{(DataW-DigitW){1'b0}}, q_r[DigitW-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.emit;
    end
  end

  assign out_valid = valid_r;
  assign out_kind  = kind_r;
  assign out_value = value_r;
  assign out_last  = last_r;

endmodule

// ===== design/fraction_decimal_expander.sv =====
// decimal expansion of dividend / divisor: integer quotient then fractional digits
// quotient word after ST_INT_DIV and ST_EMIT_INT, each digit word after ST_DIG_DIV
// and ST_EMIT_DIG; a rejected start leaves it idle, no start is taken while busy;
// restoring divider: one bit per cycle, 20 steps for the quotient, 4 per digit
// synchronous active-low reset clears controller and strobe; receiver cannot stall
module fraction_decimal_expander import fde_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [DataW-1:0]  in_dividend,
  input  logic [DataW-1:0]  in_divisor,
  input  logic [CountW-1:0] in_digit_count,
  output logic              out_valid,
  output logic              out_kind,
  output logic [DataW-1:0]  out_value,
  output logic              out_last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  fde_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_digit_count (in_digit_count),
    .stat           (stat),
    .cmd            (cmd),
    .busy           (busy)
  );

  fde_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_dividend    (in_dividend),
    .in_divisor     (in_divisor),
    .in_digit_count (in_digit_count),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_kind       (out_kind),
    .out_value      (out_value),
    .out_last       (out_last)
  );

endmodule
